/* design/signed_int_to_decimal_ascii_core_assert.svh */
// Assertion macros for the signed integer to decimal text core.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SITDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a signal holds while its transfer is stalled.
`define SITDA_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

/* design/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal text core.
// No dependencies.
package sitda_pkg;

  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned Radix            = 10;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] char_t;

  localparam char_t AsciiZero  = 8'd48;
  localparam char_t AsciiMinus = 8'd45;
  localparam char_t AsciiNine  = AsciiZero + char_t'(Radix - 1);

  // Shift-add-3 correction: a digit at or above half the radix is
  // corrected before doubling so that it carries into the next digit.
  localparam digit_t DabbleLimit = digit_t'(Radix / 2);
  localparam digit_t DabbleAdd   = digit_t'((16 - Radix) / 2);

  // Per-cycle control for the row of digit cells.
  typedef struct packed {
    logic clear;        // zero all digits
    logic dabble;       // correct and shift one binary bit in
    logic shift_digit;  // move every digit one place toward the top
  } cell_ctrl_t;

endpackage

/* design/sitda_if.sv */
// Valid/ready channels of the signed integer to decimal text core.
// Depends on sitda_pkg.
interface sitda_in_if #(
  parameter int unsigned VALUE_BITS = sitda_pkg::ValueBitsDefault
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source  (output valid, output value, input ready);
  modport sink    (input valid, input value, output ready);
  modport monitor (input valid, input value, input ready);
endinterface

interface sitda_out_if;
  logic                 valid;
  logic                 ready;
  sitda_pkg::char_t     text_byte;
  logic                 last;

  modport source  (output valid, output text_byte, output last, input ready);
  modport sink    (input valid, input text_byte, input last, output ready);
  modport monitor (input valid, input text_byte, input last, input ready);
endinterface

/* design/sitda_digit_cell.sv */
// One BCD digit cell of the conversion chain.
// Depends on sitda_pkg.
module sitda_digit_cell (
  input  logic                  clk_i,
  input  sitda_pkg::cell_ctrl_t ctrl_i,
  input  logic                  bit_i,
  input  sitda_pkg::digit_t     digit_i,
  output logic                  carry_o,
  output sitda_pkg::digit_t     digit_o
);
  import sitda_pkg::*;

  digit_t digit_q;
  digit_t digit_d;
  digit_t adj;

  // Correct the digit before doubling; its top bit carries upward.
  assign adj     = (digit_q >= DabbleLimit) ? digit_t'(digit_q + DabbleAdd) : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.shift_digit) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

/* design/signed_int_to_decimal_ascii_core.sv */
// Signed integer to decimal ASCII text. Conversion shifts the magnitude bit-serially through
// the digit cell chain, leading zeros are then skipped, and the text leaves at one byte per
// cycle while the output is not stalled. A new value is accepted only in idle, after the last
// byte of the previous text has been registered.
// Reset (async, active low) returns to idle and drops the output register.
// Depends on sitda_pkg, sitda_if and sitda_digit_cell.
module signed_int_to_decimal_ascii_core #(
  parameter int unsigned VALUE_BITS = sitda_pkg::ValueBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sitda_in_if.sink           in_i,
  sitda_out_if.source        out_o
);
  import sitda_pkg::*;

  // Decimal digits of 2^(VALUE_BITS-1): floor((VALUE_BITS-1) * log10(2)) + 1.
  localparam int unsigned NumDigits = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
  localparam int unsigned BitCntW   = $clog2(VALUE_BITS + 1);
  localparam int unsigned RemW      = $clog2(NumDigits + 1);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

  state_e                state_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic                  neg_q;
  logic [BitCntW-1:0]    bit_cnt_q;
  logic [RemW-1:0]       rem_q;
  logic                  out_valid_q;
  char_t                 out_byte_q;
  logic                  out_last_q;

  logic                  in_xfer;
  logic                  out_free;
  logic                  skip_zero;
  logic [VALUE_BITS-1:0] in_mag;
  cell_ctrl_t            ctrl;
  logic   [NumDigits:0]  carry;
  digit_t                digit [NumDigits+1];

  assign in_i.ready      = (state_q == StIdle);
  assign in_xfer         = in_i.valid && in_i.ready;
  assign out_free        = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.text_byte = out_byte_q;
  assign out_o.last      = out_last_q;

  // Magnitude as unsigned; the most negative value maps to 2^(VALUE_BITS-1).
  assign in_mag = in_i.value[VALUE_BITS-1] ? ($unsigned(~in_i.value) + VALUE_BITS'(1))
                                           : $unsigned(in_i.value);

  // Drop a leading zero while more than one digit remains.
  assign skip_zero = (digit[NumDigits] == '0) && (rem_q > RemW'(1));

  always_comb begin
    ctrl.clear       = in_xfer;
    ctrl.dabble      = (state_q == StConv);
    ctrl.shift_digit = ((state_q == StSkip) && skip_zero) ||
                       ((state_q == StEmit) && out_free);
  end

  // Row of digit cells: cell 0 takes the magnitude MSB and a zero digit.
  assign carry[0] = mag_q[VALUE_BITS-1];
  assign digit[0] = '0;

  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    sitda_digit_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .bit_i   (carry[g]),
      .digit_i (digit[g]),
      .carry_o (carry[g+1]),
      .digit_o (digit[g+1])
    );
  end

  // Sequence conversion, zero skip and byte output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            mag_q     <= in_mag;
            neg_q     <= in_i.value[VALUE_BITS-1];
            bit_cnt_q <= BitCntW'(VALUE_BITS);
            rem_q     <= RemW'(NumDigits);
            state_q   <= StConv;
          end
        end
        StConv: begin
          mag_q     <= {mag_q[VALUE_BITS-2:0], 1'b0};
          bit_cnt_q <= bit_cnt_q - BitCntW'(1);
          if (bit_cnt_q == BitCntW'(1)) begin
            state_q <= StSkip;
          end
        end
        StSkip: begin
          if (skip_zero) begin
            rem_q <= rem_q - RemW'(1);
          end else begin
            state_q <= neg_q ? StSign : StEmit;
          end
        end
        StSign: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= AsciiMinus;
            out_last_q  <= 1'b0;
            state_q     <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= AsciiZero + char_t'(digit[NumDigits]);
            out_last_q  <= (rem_q == RemW'(1));
            rem_q       <= rem_q - RemW'(1);
            if (rem_q == RemW'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

/* design/sitda_check.sv */
// Port-level checks for signed_int_to_decimal_ascii_core, bound to the top level.
// Depends on sitda_pkg and the assertion macro header.
`include "signed_int_to_decimal_ascii_core_assert.svh"

module sitda_check (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input sitda_pkg::char_t out_byte_i,
  input logic             out_last_i
);
  import sitda_pkg::*;

  logic in_xfer;
  logic is_sign;
  logic is_char;

  // Classify the input transfer and the byte on the output.
  assign in_xfer = in_valid_i && in_ready_i;
  assign is_sign = (out_byte_i == AsciiMinus);
  assign is_char = is_sign || ((out_byte_i >= AsciiZero) && (out_byte_i <= AsciiNine));

  // Hold the byte while its transfer is stalled.
  `SITDA_ASSERT_HOLD(a_out_hold, out_valid_i, out_ready_i, out_byte_i, "stalled byte changed")

  // Emit only the minus sign or a decimal digit.
  `SITDA_ASSERT(a_charset, out_valid_i |-> is_char, "byte is not a sign or digit")

  // Never close a run on the sign.
  `SITDA_ASSERT(a_sign_not_last, (out_valid_i && is_sign) |-> !out_last_i, "sign byte flagged last")

  // Drop ready after taking an item while it converts.
  `SITDA_ASSERT(a_busy_after_take, in_xfer |=> !in_ready_i, "ready held after input transfer")

endmodule

bind signed_int_to_decimal_ascii_core sitda_check u_sitda_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.text_byte),
  .out_last_i  (out_o.last)
);

/* verif/sitda_text_checker.sv */
// Scoreboard for the signed integer to decimal text core: predicts the ASCII run for
// each accepted value and compares every accepted output byte against it.
// Depends on sitda_pkg and sitda_if.
module sitda_text_checker #(
  parameter int unsigned VALUE_BITS = sitda_pkg::ValueBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sitda_in_if.monitor  in_mon_i,
  sitda_out_if.monitor out_mon_i,
  output int unsigned  pending_o,
  output int unsigned  errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sitda_pkg::*;

  typedef struct packed {
    char_t text_byte;
    logic  last;
  } text_entry_t;

  text_entry_t expected_text_q [$];
  int unsigned error_count = 0;

  // Build the decimal text of one value: sign first, then digits from the top.
  function automatic void predict_decimal_text(input logic [VALUE_BITS-1:0] value);
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude_w;
    logic [63:0]           magnitude;
    digit_t                digits [20];
    int                    count;
    text_entry_t           entry;
    negative    = value[VALUE_BITS-1];
    magnitude_w = negative ? (~value + 1'b1) : value;
    magnitude   = magnitude_w;
    count       = 0;
    do begin
      digits[count] = digit_t'(magnitude % Radix);
      magnitude     = magnitude / Radix;
      count++;
    end while (magnitude != 0);
    if (negative) begin
      entry.text_byte = AsciiMinus;
      entry.last      = 1'b0;
      expected_text_q.push_back(entry);
    end
    for (int i = count - 1; i >= 0; i--) begin
      entry.text_byte = AsciiZero + char_t'(digits[i]);
      entry.last      = (i == 0);
      expected_text_q.push_back(entry);
    end
  endfunction

  // Compare output transfers first, then queue the text of any accepted value.
  always @(posedge clk_i) begin : watch
    text_entry_t want;
    if (!rst_ni) begin
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_text_q.size() == 0) begin
          error_count++;
          $error("text_byte %0d (last %0b) arrived with nothing expected",
                 out_mon_i.text_byte, out_mon_i.last);
        end else begin
          want = expected_text_q.pop_front();
          if (out_mon_i.text_byte !== want.text_byte) begin
            error_count++;
            $error("text_byte mismatch: expected %0d, actual %0d",
                   want.text_byte, out_mon_i.text_byte);
          end
          if (out_mon_i.last !== want.last) begin
            error_count++;
            $error("last mismatch: expected %0b, actual %0b", want.last, out_mon_i.last);
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_decimal_text(in_mon_i.value);
      end
      pending_o <= expected_text_q.size();
      errors_o  <= error_count;
    end
  end

endmodule

/* verif/tb_signed_int_to_decimal_ascii_core.sv */
// Top of the decimal text core testbench: clock, reset, value stimulus with random
// gaps, random output back-pressure and the final verdict.
// Depends on sitda_pkg, sitda_if, the core and sitda_text_checker.
module tb_signed_int_to_decimal_ascii_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS   = sitda_pkg::ValueBitsDefault;
  localparam int unsigned RandomValues = 320;
  localparam int unsigned TailCycles   = 60;

  // Signs, single digits, decade edges, the extremes and alternating bit patterns.
  localparam logic signed [31:0] CornerValues [20] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'sd1000000000, 32'sd999999999,
    -32'sd999999999, 32'sd1234567890, -32'sd1234567890, 32'h5555_5555,
    32'haaaa_aaaa, 32'sd7, -32'sd5
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        calm;
  int unsigned pending;
  int unsigned errors;

  sitda_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  sitda_out_if out_ch ();

  signed_int_to_decimal_ascii_core #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sitda_text_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon_i  (in_ch),
    .out_mon_i (out_ch),
    .pending_o (pending),
    .errors_o  (errors)
  );

  always #4 clk_i = ~clk_i;

  // Stall the output about a quarter of the time, never during the calm stretch.
  always @(posedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
  end

  // Mix full-range values with short numbers, decade edges and the extremes.
  function automatic logic signed [31:0] random_value();
    int unsigned        kind;
    int unsigned        scale;
    logic signed [31:0] magnitude;
    kind  = $urandom_range(0, 9);
    scale = 1;
    case (kind)
      0, 1, 2: begin
        return $urandom;
      end
      3, 4: begin
        magnitude = $urandom_range(0, 99);
      end
      5, 6: begin
        repeat ($urandom_range(0, 9)) scale = scale * 10;
        magnitude = scale - 1 + $urandom_range(0, 2);
      end
      7, 8: begin
        repeat ($urandom_range(1, 9)) scale = scale * 10;
        magnitude = $urandom_range(0, scale - 1);
      end
      default: begin
        return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                    : 32'h8000_0000 + $urandom_range(0, 3);
      end
    endcase
    return $urandom_range(0, 1) ? -magnitude : magnitude;
  endfunction

  // Offer one value after a random gap and hold it until the transfer.
  task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Drop valid and wait until every predicted byte has come out.
  task automatic drain_text();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    calm         <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (CornerValues[i]) send_value(CornerValues[i]);
    drain_text();

    for (int unsigned i = 0; i < RandomValues; i++) begin
      calm <= (i >= 100) && (i < 180);
      send_value(random_value());
      if (i == 220) drain_text();
    end

    drain_text();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up if the core stops moving.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
